FILE: rtl/core/alw_pkg.sv
// ----------------------------------------------------------------------------
// alw_pkg: shared types and constants of the assembly line encoder
// Character classes, queue geometry and the mnemonic lookup functions.
// ----------------------------------------------------------------------------
package alw_pkg;

  // Character classes, assigned by the front end
  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_EOL   = 3'd1;
  localparam logic [2:0] CLS_SPACE = 3'd2;
  localparam logic [2:0] CLS_AT    = 3'd3;
  localparam logic [2:0] CLS_DIGIT = 3'd4;
  localparam logic [2:0] CLS_LEAD  = 3'd5;
  localparam logic [2:0] CLS_EQ    = 3'd6;
  localparam logic [2:0] CLS_SEMI  = 3'd7;

  // Token length codes
  localparam logic [2:0] LEN_EMPTY    = 3'd0;
  localparam logic [2:0] LEN_ONE      = 3'd1;
  localparam logic [2:0] LEN_TWO      = 3'd2;
  localparam logic [2:0] LEN_THREE    = 3'd3;
  localparam logic [2:0] LEN_OVERLONG = 3'd4;
  localparam logic [2:0] LEN_CLOSED   = 3'd7;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic [7:0] chr;
    logic [2:0] cls;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] code;
  } comp_dec_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } field_dec_t;

  function automatic comp_dec_t comp_lookup(input logic [2:0] len, input logic [23:0] key);
    comp_dec_t r;
    r.hit = 1'b1;
    case ({len, key})
      {LEN_ONE,   16'h0, "0"}: r.code = 7'h2A;
      {LEN_ONE,   16'h0, "1"}: r.code = 7'h3F;
      {LEN_ONE,   16'h0, "D"}: r.code = 7'h0C;
      {LEN_ONE,   16'h0, "A"}: r.code = 7'h30;
      {LEN_ONE,   16'h0, "M"}: r.code = 7'h70;
      {LEN_TWO,   8'h0, "-1"}: r.code = 7'h3A;
      {LEN_TWO,   8'h0, "!D"}: r.code = 7'h0D;
      {LEN_TWO,   8'h0, "!A"}: r.code = 7'h31;
      {LEN_TWO,   8'h0, "-D"}: r.code = 7'h0F;
      {LEN_TWO,   8'h0, "-A"}: r.code = 7'h33;
      {LEN_TWO,   8'h0, "!M"}: r.code = 7'h71;
      {LEN_TWO,   8'h0, "-M"}: r.code = 7'h73;
      {LEN_THREE, "D+1"}:      r.code = 7'h1F;
      {LEN_THREE, "A+1"}:      r.code = 7'h37;
      {LEN_THREE, "D-1"}:      r.code = 7'h0E;
      {LEN_THREE, "A-1"}:      r.code = 7'h32;
      {LEN_THREE, "D+A"}:      r.code = 7'h02;
      {LEN_THREE, "D-A"}:      r.code = 7'h13;
      {LEN_THREE, "A-D"}:      r.code = 7'h07;
      {LEN_THREE, "D&A"}:      r.code = 7'h00;
      {LEN_THREE, "D|A"}:      r.code = 7'h15;
      {LEN_THREE, "M+1"}:      r.code = 7'h77;
      {LEN_THREE, "M-1"}:      r.code = 7'h72;
      {LEN_THREE, "D+M"}:      r.code = 7'h42;
      {LEN_THREE, "D-M"}:      r.code = 7'h53;
      {LEN_THREE, "M-D"}:      r.code = 7'h47;
      {LEN_THREE, "D&M"}:      r.code = 7'h40;
      {LEN_THREE, "D|M"}:      r.code = 7'h55;
      default: begin
        r.hit  = 1'b0;
        r.code = 7'h00;
      end
    endcase
    return r;
  endfunction

  function automatic field_dec_t dest_lookup(input logic [2:0] len, input logic [23:0] key);
    field_dec_t r;
    r.hit = 1'b1;
    case ({len, key})
      {LEN_ONE,   16'h0, "M"}: r.code = 3'd1;
      {LEN_ONE,   16'h0, "D"}: r.code = 3'd2;
      {LEN_TWO,   8'h0, "MD"}: r.code = 3'd3;
      {LEN_ONE,   16'h0, "A"}: r.code = 3'd4;
      {LEN_TWO,   8'h0, "AM"}: r.code = 3'd5;
      {LEN_TWO,   8'h0, "AD"}: r.code = 3'd6;
      {LEN_THREE, "AMD"}:      r.code = 3'd7;
      default: begin
        r.hit  = 1'b0;
        r.code = 3'd0;
      end
    endcase
    return r;
  endfunction

  function automatic field_dec_t jump_lookup(input logic [2:0] len, input logic [23:0] key);
    field_dec_t r;
    r.hit = 1'b1;
    case ({len, key})
      {LEN_THREE, "JGT"}: r.code = 3'd1;
      {LEN_THREE, "JEQ"}: r.code = 3'd2;
      {LEN_THREE, "JGE"}: r.code = 3'd3;
      {LEN_THREE, "JLT"}: r.code = 3'd4;
      {LEN_THREE, "JNE"}: r.code = 3'd5;
      {LEN_THREE, "JLE"}: r.code = 3'd6;
      {LEN_THREE, "JMP"}: r.code = 3'd7;
      default: begin
        r.hit  = 1'b0;
        r.code = 3'd0;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/alw_front.sv
// ----------------------------------------------------------------------------
// alw_front: character classifier
// Tags each incoming character with its class before it enters the queue.
// ----------------------------------------------------------------------------
module alw_front
  import alw_pkg::*;
(
  input  logic [7:0] chr,
  output item_t      item
);

  logic [2:0] cls;

  always_comb begin
    if (chr inside {8'd13, 8'd10}) begin
      cls = CLS_EOL;
    end else if (chr == " ") begin
      cls = CLS_SPACE;
    end else if (chr == "@") begin
      cls = CLS_AT;
    end else if (chr inside {["0":"9"]}) begin
      cls = CLS_DIGIT;
    end else if (chr inside {"A", "M", "D", "J"}) begin
      cls = CLS_LEAD;
    end else if (chr == "=") begin
      cls = CLS_EQ;
    end else if (chr == ";") begin
      cls = CLS_SEMI;
    end else begin
      cls = CLS_OTHER;
    end
  end

  assign item.chr = chr;
  assign item.cls = cls;

endmodule

FILE: rtl/core/alw_queue.sv
// ----------------------------------------------------------------------------
// alw_queue: short FIFO between classifier and line engine
// Register-based, one push and one pop per cycle; a push is ignored while full and a pop while empty.
// ----------------------------------------------------------------------------
module alw_queue
  import alw_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head_item,
  output q_stat_t stat
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/core/alw_back.sv
// ----------------------------------------------------------------------------
// alw_back: line engine
// Tracks the current line, builds address values and compute fields, and
// loads the finished word into the output register at end of line.
// ----------------------------------------------------------------------------
module alw_back
  import alw_pkg::*;
#(
  parameter int VALUE_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_word,
  output logic        out_bad
);

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_ADDR   = 2'd1;
  localparam logic [1:0] KIND_COMP   = 2'd2;
  localparam logic [1:0] KIND_IGNORE = 2'd3;

  logic [1:0]            kind_r, kind_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [23:0]           tok_r, tok_nxt;
  logic [2:0]            len_r, len_nxt;
  logic [2:0]            dest_r, dest_nxt;
  logic [6:0]            comp_r, comp_nxt;
  logic                  semi_r, semi_nxt;
  logic                  err_r, err_nxt;
  logic                  ovalid_r;
  logic [15:0]           word_r, word_nxt;
  logic                  bad_r, bad_nxt;
  logic                  emit;
  logic                  take;

  comp_dec_t             cd;
  field_dec_t            dd, jd;
  logic [6:0]            close_comp;
  logic [2:0]            close_jump;
  logic                  close_fail;
  logic [VALUE_BITS+3:0] acc_sum;
  logic [2:0]            cls;
  logic [7:0]            chr;

  assign take      = q_valid && (!ovalid_r || out_ready);
  assign q_pop     = take;
  assign out_valid = ovalid_r;
  assign out_word  = word_r;
  assign out_bad   = bad_r;
  assign cls       = q_item.cls;
  assign chr       = q_item.chr;

  assign cd = comp_lookup(len_r, tok_r);
  assign dd = dest_lookup(len_r, tok_r);
  assign jd = jump_lookup(len_r, tok_r);

  // Closing the final token: comp when no ';' was seen, jump otherwise
  assign close_comp = semi_r ? comp_r : cd.code;
  assign close_jump = semi_r ? jd.code : 3'd0;
  assign close_fail = semi_r ? !jd.hit : !cd.hit;

  assign acc_sum = ((VALUE_BITS+4)'(acc_r) << 3) + ((VALUE_BITS+4)'(acc_r) << 1)
                   + (VALUE_BITS+4)'(chr[3:0]);

  always_comb begin
    kind_nxt = kind_r;
    acc_nxt  = acc_r;
    tok_nxt  = tok_r;
    len_nxt  = len_r;
    dest_nxt = dest_r;
    comp_nxt = comp_r;
    semi_nxt = semi_r;
    err_nxt  = err_r;
    emit     = 1'b0;
    word_nxt = word_r;
    bad_nxt  = bad_r;

    case (kind_r)
      KIND_START: begin
        if (cls == CLS_AT) begin
          kind_nxt = KIND_ADDR;
        end else if (cls inside {CLS_DIGIT, CLS_LEAD}) begin
          kind_nxt = KIND_COMP;
          tok_nxt  = {tok_r[15:0], chr};
          len_nxt  = LEN_ONE;
        end else if (!(cls inside {CLS_EOL, CLS_SPACE})) begin
          kind_nxt = KIND_IGNORE;
        end
      end
      KIND_ADDR: begin
        if (cls == CLS_EOL) begin
          emit     = 1'b1;
          word_nxt = 16'(acc_r);
          bad_nxt  = 1'b0;
        end else if (!semi_r) begin
          if (cls == CLS_DIGIT) begin
            acc_nxt = acc_sum[VALUE_BITS-1:0];
            len_nxt = LEN_ONE;
          end else if (!(cls == CLS_SPACE && len_r == LEN_EMPTY)) begin
            // Anything else ends the number; drop the rest of the line
            semi_nxt = 1'b1;
          end
        end
      end
      KIND_COMP: begin
        if (cls == CLS_EOL) begin
          emit = 1'b1;
          if (len_r == LEN_CLOSED) begin
            word_nxt = {3'b111, comp_r, dest_r, tok_r[2:0]};
            bad_nxt  = err_r;
          end else begin
            word_nxt = {3'b111, close_comp, dest_r, close_jump};
            bad_nxt  = err_r | close_fail;
          end
        end else if (len_r != LEN_CLOSED) begin
          if (cls == CLS_SPACE) begin
            comp_nxt = close_comp;
            tok_nxt  = {21'd0, close_jump};
            len_nxt  = LEN_CLOSED;
            err_nxt  = err_r | close_fail;
          end else if (cls == CLS_EQ) begin
            dest_nxt = dd.code;
            err_nxt  = err_r | !dd.hit | semi_r;
            tok_nxt  = '0;
            len_nxt  = LEN_EMPTY;
          end else if (cls == CLS_SEMI) begin
            if (semi_r) begin
              err_nxt = 1'b1;
            end else begin
              comp_nxt = cd.code;
              err_nxt  = err_r | !cd.hit;
            end
            semi_nxt = 1'b1;
            tok_nxt  = '0;
            len_nxt  = LEN_EMPTY;
          end else if (len_r < LEN_THREE) begin
            tok_nxt = {tok_r[15:0], chr};
            len_nxt = len_r + 3'd1;
          end else begin
            len_nxt = LEN_OVERLONG;
          end
        end
      end
      default: begin
      end
    endcase

    // End of line returns every kind of line to line start
    if (cls == CLS_EOL) begin
      kind_nxt = KIND_START;
      acc_nxt  = '0;
      tok_nxt  = '0;
      len_nxt  = LEN_EMPTY;
      dest_nxt = '0;
      comp_nxt = '0;
      semi_nxt = 1'b0;
      err_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_START;
      acc_r    <= '0;
      tok_r    <= '0;
      len_r    <= LEN_EMPTY;
      dest_r   <= '0;
      comp_r   <= '0;
      semi_r   <= 1'b0;
      err_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (take) begin
        kind_r <= kind_nxt;
        acc_r  <= acc_nxt;
        tok_r  <= tok_nxt;
        len_r  <= len_nxt;
        dest_r <= dest_nxt;
        comp_r <= comp_nxt;
        semi_r <= semi_nxt;
        err_r  <= err_nxt;
      end
      if (take && emit) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      word_r <= word_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule

FILE: rtl/core/assembly_line_to_machine_word.sv
// ----------------------------------------------------------------------------
// assembly_line_to_machine_word: assembly text to 16-bit instruction encoder
// Classifies and queues one character per cycle while the queue has room;
// the line engine emits one instruction word per address or compute line.
// ----------------------------------------------------------------------------
// Path: a line-ending character is first written into the queue; the line
//   engine loads its word into the output register when it pops that
//   entry, and the word is offered from that register.
// Throughput: one character per cycle while the queue has room; the engine
//   pops one entry per cycle while the output register is free or being drained.
// Reset: synchronous active-low rst_n empties the queue, drops any pending
//   output word and returns the line engine to line start.
// ----------------------------------------------------------------------------
module assembly_line_to_machine_word
  import alw_pkg::*;
#(
  parameter int VALUE_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream: one text character per word
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_char
  // Result stream: one machine word per instruction line
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] machine_word
  output logic        out_tuser   // [0] bad_mnemonic
);

  item_t   front_item;
  item_t   head_item;
  q_stat_t q_stat;
  logic    in_take;
  logic    q_pop;

  // Accept a character whenever the queue has room
  assign in_tready = !q_stat.full;
  assign in_take   = in_tvalid && in_tready;

  // Front: tag each character with its class
  alw_front u_front (
    .chr  (in_tdata),
    .item (front_item)
  );

  // Queue: decouple the classifier from the line engine
  alw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_item (front_item),
    .pop       (q_pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  // Back: advance the line state and hold finished words in the output register
  alw_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_stat.empty),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_tdata),
    .out_bad   (out_tuser)
  );

  // Address words never carry the error flag
  a_addr_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[15] |-> !out_tuser)
    else $error("address word flagged as bad mnemonic");

  // Compute words always carry the 111 prefix
  a_comp_prefix : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[15] |-> out_tdata[14:13] == 2'b11)
    else $error("compute word without 111 prefix");

  // An accepted character is held in the queue on the following cycle
  a_queue_holds : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !q_stat.empty)
    else $error("accepted character lost by queue");

  // The queue never reports full and empty together
  a_queue_stat : assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

endmodule

FILE: dv/assembly_line_to_machine_word_tb.sv
// ----------------------------------------------------------------------------
// assembly_line_to_machine_word_tb: self-checking bench of the line encoder
// Streams assembly text one character per word into the encoder and
// predicts the instruction word of every address or compute line. Each word
// that leaves the block is checked as a whole, with its bad-mnemonic flag,
// against the oldest prediction. The run covers directed lines, random lines
// under several idle and stall mixes, and one long output hold-off.
// ----------------------------------------------------------------------------
module assembly_line_to_machine_word_tb;
  import alw_pkg::LEN_EMPTY;
  import alw_pkg::LEN_THREE;
  import alw_pkg::LEN_OVERLONG;

  localparam int ADDR_BITS    = 15;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT      = 2_000_000;
  localparam int MAX_REPORTS  = 50;

  localparam logic [7:0] CHR_CR = 8'd13;
  localparam logic [7:0] CHR_LF = 8'd10;

  typedef enum logic [1:0] {
    AT_LINE_START,
    IN_ADDRESS,
    IN_COMPUTE,
    IN_SKIPPED
  } line_state_e;

  typedef struct packed {
    logic [15:0] word;
    logic        bad;
  } encoded_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  assembly_line_to_machine_word #(
    .VALUE_BITS(ADDR_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // [7:0] text_char
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // [15:0] machine_word
    .out_tuser (out_tuser)   // [0] bad_mnemonic
  );

  // Characters waiting to be sent, and words predicted but not yet seen
  logic [7:0]    text_q[$];
  encoded_word_t encoded_q[$];

  int mismatches = 0;

  // Idle mix of the current phase, in percent
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_armed = 1'b0;
  int hold_count = 0;

  // Encoder shadow state
  line_state_e line_state;
  logic [14:0] addr_value;
  logic        addr_digits_seen;
  logic        addr_number_done;
  logic [23:0] tok_chars;
  logic [2:0]  tok_len;
  logic        text_closed;
  logic [2:0]  dest_field;
  logic [6:0]  comp_field;
  logic [2:0]  jump_field;
  logic        jump_started;
  logic        line_bad;

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Mnemonic decode. A key holds the token characters right-aligned, so a
  // known mnemonic implies its own length: the count of bytes from the first
  // nonzero one down. A token only matches when its length agrees, which
  // rejects keys padded with NUL characters.
  // --------------------------------------------------------------------------
  function automatic logic [2:0] mnemonic_len(input logic [23:0] key);
    if (key[23:16] != 8'h00) return 3'd3;
    if (key[15:8] != 8'h00) return 3'd2;
    return 3'd1;
  endfunction

  // Return {known, code}; code is zero when the token is unknown
  function automatic logic [7:0] comp_decode(input logic [2:0] len, input logic [23:0] key);
    logic [6:0] code;
    logic       known;
    known = 1'b1;
    case (key)
      "0":   code = 7'h2A;
      "1":   code = 7'h3F;
      "-1":  code = 7'h3A;
      "D":   code = 7'h0C;
      "A":   code = 7'h30;
      "!D":  code = 7'h0D;
      "!A":  code = 7'h31;
      "-D":  code = 7'h0F;
      "-A":  code = 7'h33;
      "D+1": code = 7'h1F;
      "A+1": code = 7'h37;
      "D-1": code = 7'h0E;
      "A-1": code = 7'h32;
      "D+A": code = 7'h02;
      "D-A": code = 7'h13;
      "A-D": code = 7'h07;
      "D&A": code = 7'h00;
      "D|A": code = 7'h15;
      "M":   code = 7'h70;
      "!M":  code = 7'h71;
      "-M":  code = 7'h73;
      "M+1": code = 7'h77;
      "M-1": code = 7'h72;
      "D+M": code = 7'h42;
      "D-M": code = 7'h53;
      "M-D": code = 7'h47;
      "D&M": code = 7'h40;
      "D|M": code = 7'h55;
      default: begin
        known = 1'b0;
        code  = 7'h00;
      end
    endcase
    if (!known || len != mnemonic_len(key)) return 8'h00;
    return {1'b1, code};
  endfunction

  function automatic logic [3:0] dest_decode(input logic [2:0] len, input logic [23:0] key);
    logic [2:0] code;
    logic       known;
    known = 1'b1;
    case (key)
      "M":   code = 3'd1;
      "D":   code = 3'd2;
      "MD":  code = 3'd3;
      "A":   code = 3'd4;
      "AM":  code = 3'd5;
      "AD":  code = 3'd6;
      "AMD": code = 3'd7;
      default: begin
        known = 1'b0;
        code  = 3'd0;
      end
    endcase
    if (!known || len != mnemonic_len(key)) return 4'h0;
    return {1'b1, code};
  endfunction

  function automatic logic [3:0] jump_decode(input logic [2:0] len, input logic [23:0] key);
    logic [2:0] code;
    logic       known;
    known = 1'b1;
    case (key)
      "JGT": code = 3'd1;
      "JEQ": code = 3'd2;
      "JGE": code = 3'd3;
      "JLT": code = 3'd4;
      "JNE": code = 3'd5;
      "JLE": code = 3'd6;
      "JMP": code = 3'd7;
      default: begin
        known = 1'b0;
        code  = 3'd0;
      end
    endcase
    if (!known || len != mnemonic_len(key)) return 4'h0;
    return {1'b1, code};
  endfunction

  // --------------------------------------------------------------------------
  // Line predictor
  // --------------------------------------------------------------------------
  task automatic clear_line();
    line_state       = AT_LINE_START;
    addr_value       = '0;
    addr_digits_seen = 1'b0;
    addr_number_done = 1'b0;
    tok_chars        = '0;
    tok_len          = LEN_EMPTY;
    text_closed      = 1'b0;
    dest_field       = '0;
    comp_field       = '0;
    jump_field       = '0;
    jump_started     = 1'b0;
    line_bad         = 1'b0;
  endtask

  task automatic take_char(input logic [7:0] c);
    if (tok_len < LEN_THREE) begin
      tok_chars = {tok_chars[15:0], c};
      tok_len   = tok_len + 3'd1;
    end else begin
      tok_len = LEN_OVERLONG;
    end
  endtask

  // Close the instruction text: the last token is comp, or jump after ';'
  task automatic close_text();
    logic [7:0] comp_hit;
    logic [3:0] jump_hit;
    if (text_closed) return;
    if (!jump_started) begin
      comp_hit   = comp_decode(tok_len, tok_chars);
      comp_field = comp_hit[6:0];
      if (!comp_hit[7]) line_bad = 1'b1;
    end else begin
      jump_hit   = jump_decode(tok_len, tok_chars);
      jump_field = jump_hit[2:0];
      if (!jump_hit[3]) line_bad = 1'b1;
    end
    text_closed = 1'b1;
  endtask

  // Advance the shadow encoder by one character; queue a word at line end
  task automatic encode_char(input logic [7:0] c);
    logic          eol;
    logic          digit;
    logic [31:0]   grown;
    logic [7:0]    comp_hit;
    logic [3:0]    dest_hit;
    encoded_word_t w;
    eol   = (c == CHR_CR) || (c == CHR_LF);
    digit = (c >= "0") && (c <= "9");
    case (line_state)
      AT_LINE_START: begin
        if (!eol && c != " ") begin
          if (c == "@") begin
            line_state = IN_ADDRESS;
          end else if (digit || c == "A" || c == "M" || c == "D" || c == "J") begin
            line_state = IN_COMPUTE;
            take_char(c);
          end else begin
            line_state = IN_SKIPPED;
          end
        end
      end
      IN_ADDRESS: begin
        if (eol) begin
          w.word = {1'b0, addr_value};
          w.bad  = 1'b0;
          encoded_q.push_back(w);
          clear_line();
        end else if (!addr_number_done) begin
          if (digit) begin
            grown = 32'(addr_value) * 32'd10 + 32'(c - "0");
            addr_value = 15'(grown % (32'd1 << ADDR_BITS));
            addr_digits_seen = 1'b1;
          end else if (!(c == " " && !addr_digits_seen)) begin
            // first non-digit ends the number; ignore the rest of the line
            addr_number_done = 1'b1;
          end
        end
      end
      IN_COMPUTE: begin
        if (eol) begin
          close_text();
          w.word = {3'b111, comp_field, dest_field, jump_field};
          w.bad  = line_bad;
          encoded_q.push_back(w);
          clear_line();
        end else if (!text_closed) begin
          if (c == " ") begin
            close_text();
          end else if (c == "=") begin
            dest_hit   = dest_decode(tok_len, tok_chars);
            dest_field = dest_hit[2:0];
            if (!dest_hit[3] || jump_started) line_bad = 1'b1;
            tok_chars = '0;
            tok_len   = LEN_EMPTY;
          end else if (c == ";") begin
            if (jump_started) begin
              line_bad = 1'b1;
            end else begin
              comp_hit   = comp_decode(tok_len, tok_chars);
              comp_field = comp_hit[6:0];
              if (!comp_hit[7]) line_bad = 1'b1;
            end
            jump_started = 1'b1;
            tok_chars    = '0;
            tok_len      = LEN_EMPTY;
          end else begin
            take_char(c);
          end
        end
      end
      default: begin
        if (eol) clear_line();
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next character whenever the current word is taken
  // or none is offered; drop valid on a random idle cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= text_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls; once armed, hold ready low for a long stretch so
  // the internal queue fills and the input side backs up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_armed && hold_count < HOLD_CYCLES) begin
      hold_count = hold_count + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted character, check every accepted word.
  // A line end passes through the queue and the output register before its
  // word can leave, so the prediction is always queued first.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    encoded_word_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) encode_char(in_tdata);
      if (out_tvalid && out_tready) begin
        if (encoded_q.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected word: expected none, actual %h/%b",
                     $time, out_tdata, out_tuser);
        end else begin
          want = encoded_q.pop_front();
          if (out_tdata !== want.word) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: machine_word mismatch: expected %h, actual %h",
                       $time, want.word, out_tdata);
          end
          if (out_tuser !== want.bad) begin
            mismatches = mismatches + 1;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: bad_mnemonic mismatch: expected %b, actual %b (word %h)",
                       $time, want.bad, out_tuser, want.word);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic string dest_text(input int i);
    case (i)
      0: return "M";
      1: return "D";
      2: return "MD";
      3: return "A";
      4: return "AM";
      5: return "AD";
      default: return "AMD";
    endcase
  endfunction

  function automatic string jump_text(input int i);
    case (i)
      0: return "JGT";
      1: return "JEQ";
      2: return "JGE";
      3: return "JLT";
      4: return "JNE";
      5: return "JLE";
      default: return "JMP";
    endcase
  endfunction

  function automatic string comp_text(input int i);
    case (i)
      0:  return "0";
      1:  return "1";
      2:  return "-1";
      3:  return "D";
      4:  return "A";
      5:  return "!D";
      6:  return "!A";
      7:  return "-D";
      8:  return "-A";
      9:  return "D+1";
      10: return "A+1";
      11: return "D-1";
      12: return "A-1";
      13: return "D+A";
      14: return "D-A";
      15: return "A-D";
      16: return "D&A";
      17: return "D|A";
      18: return "M";
      19: return "!M";
      20: return "-M";
      21: return "M+1";
      22: return "M-1";
      23: return "D+M";
      24: return "D-M";
      25: return "M-D";
      26: return "D&M";
      default: return "D|M";
    endcase
  endfunction

  // Queue a line and end it with LF, CR or CR LF
  task automatic send_line(input string s);
    int i;
    for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    case ($urandom_range(2))
      0: text_q.push_back(CHR_LF);
      1: text_q.push_back(CHR_CR);
      default: begin
        text_q.push_back(CHR_CR);
        text_q.push_back(CHR_LF);
      end
    endcase
  endtask

  function automatic string random_compute();
    string s;
    s = "";
    if ($urandom_range(4) == 0) s = "  ";
    if ($urandom_range(1) == 1) s = {s, dest_text($urandom_range(6)), "="};
    s = {s, comp_text($urandom_range(27))};
    if ($urandom_range(1) == 1) s = {s, ";", jump_text($urandom_range(6))};
    if ($urandom_range(7) == 0) s = {s, " // note"};
    return s;
  endfunction

  // Queue one random line; count the characters of address, compute and mutated lines
  task automatic send_random_line(inout int counted);
    string s;
    string charset;
    string mutant;
    int    pick;
    int    pos;
    int    n;
    int    i;
    charset = "AMDJ01-+!&|=;Xq @";
    pick = $urandom_range(99);
    if (pick < 30) begin
      s = ($urandom_range(3) == 0) ? " @" : "@";
      case ($urandom_range(5))
        0: s = {s, "  ", $sformatf("%0d", $urandom_range(32767))};
        1: s = {s, $sformatf("%0d", $urandom_range(999999))};
        2: s = {s, $sformatf("%0d %0d", $urandom_range(99), $urandom_range(9))};
        3: s = {s, "R", $sformatf("%0d", $urandom_range(15))};
        default: s = {s, $sformatf("%0d", $urandom_range(32767))};
      endcase
      send_line(s);
      counted = counted + s.len() + 1;
    end else if (pick < 75) begin
      s = random_compute();
      send_line(s);
      counted = counted + s.len() + 1;
    end else if (pick < 87) begin
      // break a well-formed line by swapping one character
      s      = random_compute();
      pos    = $urandom_range(s.len() - 1);
      mutant = charset.substr($urandom_range(charset.len() - 1), 0);
      mutant = charset.substr(pos % charset.len(), pos % charset.len());
      mutant = charset.substr($urandom_range(charset.len() - 1),
                              $urandom_range(charset.len() - 1));
      if (mutant.len() != 1) mutant = "=";
      s = {s.substr(0, pos - 1), mutant, s.substr(pos + 1, s.len() - 1)};
      send_line(s);
      counted = counted + s.len() + 1;
    end else if (pick < 95) begin
      // raw bytes, any value, stray line ends included
      n = $urandom_range(1, 8);
      for (i = 0; i < n; i++) text_q.push_back(8'($urandom_range(255)));
      send_line("");
    end else begin
      case ($urandom_range(2))
        0: send_line("(LOOP)");
        1: send_line("// comment");
        default: send_line("");
      endcase
    end
  endtask

  // Hold until every character is taken and every predicted word is seen
  task automatic wait_drained();
    while (text_q.size() != 0 || in_tvalid || encoded_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int chars);
    int counted;
    counted = 0;
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (counted < chars) send_random_line(counted);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed lines, then random phases
  // --------------------------------------------------------------------------
  initial begin
    clear_line();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // address extremes, wrap, spacing, symbols and empty number
    send_line("@0");
    send_line("@32767");
    send_line("@32768");
    send_line("@  12 x");
    send_line("@");
    send_line("@R5");
    // empty line and CR LF pair produce nothing
    text_q.push_back(CHR_CR);
    text_q.push_back(CHR_LF);
    // full and partial compute lines
    send_line("AMD=D|M;JMP");
    send_line("  M=!M trailing text");
    send_line("0;JMP");
    send_line("D;JLE");
    // ignored lines
    send_line("(LOOP)");
    send_line("X=1");
    // bad tokens: unknown, empty, overlong
    send_line("A=Q");
    send_line("D=");
    send_line("D;");
    send_line("ABCD=1");
    // misplaced separators
    send_line("D;JMP=A");
    send_line("D;JGT;JEQ");
    send_line("A=D=M");
    wait_drained();

    run_phase(0, 0, 300);
    run_phase(56, 0, 300);
    run_phase(0, 56, 300);
    run_phase(36, 36, 300);

    // long receiver hold-off with the sender running flat out
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_armed     = 1'b1;
    run_phase(0, 0, 200);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && encoded_q.size() == 0) begin
      $display("assembly_line_to_machine_word regression: pass");
    end else begin
      $display("assembly_line_to_machine_word regression: fail");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #(TIMEOUT);
    $display("assembly_line_to_machine_word regression: fail");
    $finish;
  end

endmodule
